@@ rtl/slbph_pkg.sv @@
// Shared types and codes of the segmented level bar.
package slbph_pkg;

   typedef enum logic [3:0] {
      KIND_ACCEPTED  = 4'd0,
      KIND_TOO_LARGE = 4'd1,
      KIND_TOO_SMALL = 4'd2,
      KIND_FILL      = 4'd3,
      KIND_ERASE     = 4'd4,
      KIND_UNMARK    = 4'd5,
      KIND_RESTORE   = 4'd6,
      KIND_MARK      = 4'd7,
      KIND_NO_CHANGE = 4'd8
   } kind_type;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_UPDATE = 1'b1
   } op_type;

   localparam logic [2:0] REG_MIN_VALUE    = 3'd0;
   localparam logic [2:0] REG_MAX_VALUE    = 3'd1;
   localparam logic [2:0] REG_NUM_SEGMENTS = 3'd2;
   localparam logic [2:0] REG_BACKGROUND   = 3'd3;
   localparam logic [2:0] REG_BORDER       = 3'd4;
   localparam logic [2:0] REG_COLOR_LOW    = 3'd5;
   localparam logic [2:0] REG_COLOR_MID    = 3'd6;
   localparam logic [2:0] REG_COLOR_HIGH   = 3'd7;

   localparam logic [31:0] BUCKET_MS = 32'd1000;

   typedef struct packed {
      op_type      operation;
      logic [15:0] sample_value;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  segment;
      logic [15:0] color;
      logic [5:0]  lit_count;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [15:0] min_value;
      logic [15:0] max_value;
      logic [5:0]  num_segments;
      logic [15:0] background_color;
      logic [15:0] border_color;
      logic [15:0] color_low;
      logic [15:0] color_mid;
      logic [15:0] color_high;
   } cfg_type;

endpackage

@@ rtl/segmented_level_bar_with_peak_hold.sv @@
// Top level: configuration registers, input queue and command sequencer.
// An add item presents a single result.
// An update walks the peak window, then runs one division, or three with a peak move;
// it then presents its commands one per cycle while rsp_tready is high.
// Synchronous active-high reset clears the accumulators, peak window and shown bar.
module segmented_level_bar_with_peak_hold
   import slbph_pkg::*;
#(
   parameter int SEGMENTS_MAX = 32,
   parameter int PEAK_WINDOW  = 8,
   parameter int COUNT_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sample_value[15:0], now_ms[47:16]
   input  logic [0:0]  req_tuser,   // operation[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // segment[4:0], color[20:5], lit_count[26:21], zero
   output logic [3:0]  rsp_tuser,   // kind[3:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   logic       item_valid;
   logic       item_ready;
   item_type   item;
   result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_value        <= 16'd0;
         cfg_ff.max_value        <= 16'hFFFF;
         cfg_ff.num_segments     <= 6'd8;
         cfg_ff.background_color <= 16'd0;
         cfg_ff.border_color     <= 16'hFFFF;
         cfg_ff.color_low        <= 16'd0;
         cfg_ff.color_mid        <= 16'd0;
         cfg_ff.color_high       <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MIN_VALUE:    cfg_ff.min_value        <= csr_wdata;
            REG_MAX_VALUE:    cfg_ff.max_value        <= csr_wdata;
            REG_NUM_SEGMENTS: cfg_ff.num_segments     <= csr_wdata[5:0];
            REG_BACKGROUND:   cfg_ff.background_color <= csr_wdata;
            REG_BORDER:       cfg_ff.border_color     <= csr_wdata;
            REG_COLOR_LOW:    cfg_ff.color_low        <= csr_wdata;
            REG_COLOR_MID:    cfg_ff.color_mid        <= csr_wdata;
            REG_COLOR_HIGH:   cfg_ff.color_high       <= csr_wdata;
            default:          cfg_ff.color_high       <= cfg_ff.color_high;
         endcase
      end
   end

   slbph_front u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .item_valid(item_valid),
      .item_ready(item_ready),
      .item(item)
   );

   slbph_back #(
      .SEGMENTS_MAX(SEGMENTS_MAX),
      .PEAK_WINDOW(PEAK_WINDOW),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .item_valid(item_valid),
      .item_ready(item_ready),
      .item(item),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp(res)
   );

   assign rsp_tdata = {5'd0, res.lit_count, res.color, res.segment};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;

endmodule

@@ rtl/slbph_front.sv @@
// Input side: unpacks stream items and buffers them in a two-entry queue.
module slbph_front
   import slbph_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [0:0]  req_tuser,
   output logic        item_valid,
   input  logic        item_ready,
   output item_type    item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   incoming;
   logic       push;
   logic       pop;

   always_comb begin
      incoming.operation    = op_type'(req_tuser[0]);
      incoming.sample_value = req_tdata[15:0];
      incoming.now_ms       = req_tdata[47:16];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= incoming;
            wr_ptr_ff           <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

@@ rtl/slbph_div.sv @@
// Restoring divider, one quotient bit per cycle.
module slbph_div
   import slbph_pkg::*;
#(
   parameter int NUM_W = 40,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] qn_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] diff;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, qn_ff[NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, den_ff};
      ge     = !diff[DEN_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            qn_ff   <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            qn_ff  <= {qn_ff[NUM_W-2:0], ge};
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = qn_ff;

endmodule

@@ rtl/slbph_back.sv @@
// Execution side: sample accumulation, peak window, bar mapping and command output.
module slbph_back
   import slbph_pkg::*;
#(
   parameter int SEGMENTS_MAX = 32,
   parameter int PEAK_WINDOW  = 8,
   parameter int COUNT_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   output logic       item_ready,
   input  item_type   item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam int SEG_W     = $clog2(SEGMENTS_MAX + 1);
   localparam int PROD_A_W  = 32 + SEG_W;
   localparam int PROD_B_W  = COUNT_BITS + 16;
   localparam int NUM_W     = ((PROD_A_W + 1 > PROD_B_W) ? PROD_A_W + 1 : PROD_B_W) + 1;
   localparam int DEN_W     = PROD_B_W + 1;
   localparam int WALK_W    = (PEAK_WINDOW > 1) ? $clog2(PEAK_WINDOW) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_PEAK, S_MUL, S_DIVST, S_DIVWAIT, S_PLAN,
      S_BAR, S_UNMARK, S_RESTORE, S_MARK, S_NONE
   } state_type;

   typedef enum logic [1:0] {SEL_LIT, SEL_OLD, SEL_NEW} sel_type;

   state_type             state_ff;
   sel_type               sel_ff;
   item_type              item_ff;
   logic [31:0]           sum_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [SEG_W-1:0]      shown_lit_ff;
   logic [15:0]           shown_peak_ff;
   logic [15:0]           bucket_ff [PEAK_WINDOW];
   logic                  bucket_open_ff;
   logic [31:0]           start_ms_ff;
   logic [WALK_W-1:0]     walk_ff;
   logic [15:0]           peak_ff;
   logic [PROD_A_W-1:0]   prod_a_ff;
   logic [PROD_B_W-1:0]   prod_b_ff;
   logic                  zero_ff;
   logic [SEG_W-1:0]      lit_ff;
   logic [SEG_W-1:0]      old_ff;
   logic [SEG_W-1:0]      new_ff;
   logic                  pm_ff;
   logic [SEG_W-1:0]      idx_ff;
   logic [SEG_W-1:0]      end_ff;
   logic                  grow_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;

   logic [SEG_W-1:0]      n_eff;
   logic [15:0]           mx_eff;
   logic [31:0]           div_s;
   logic [COUNT_BITS-1:0] div_c;
   logic [NUM_W-1:0]      div_num;
   logic [DEN_W-1:0]      div_den;
   logic                  div_start;
   logic                  div_busy;
   logic                  div_done;
   logic [NUM_W-1:0]      div_quot;
   logic [SEG_W-1:0]      capped;
   logic                  can_emit;
   logic                  emit;
   result_type            emit_res;
   logic                  commit;
   state_type             post_bar;
   kind_type              add_kind;
   logic [32:0]           sum_wide;
   logic [SEG_W+1:0]      three_q;
   logic [15:0]           bar_color;

   always_comb begin
      if (32'(cfg.num_segments) > 32'(SEGMENTS_MAX)) begin
         n_eff = SEG_W'(SEGMENTS_MAX);
      end else if (cfg.num_segments == 6'd0) begin
         n_eff = SEG_W'(1);
      end else begin
         n_eff = SEG_W'(cfg.num_segments);
      end
      mx_eff = (cfg.max_value == 16'd0) ? 16'd1 : cfg.max_value;
   end

   always_comb begin
      case (sel_ff)
         SEL_LIT: begin
            div_s = sum_ff;
            div_c = count_ff;
         end
         SEL_OLD: begin
            div_s = {16'd0, shown_peak_ff};
            div_c = COUNT_BITS'(1);
         end
         default: begin
            div_s = {16'd0, peak_ff};
            div_c = COUNT_BITS'(1);
         end
      endcase
      div_num   = NUM_W'({prod_a_ff, 1'b0}) + NUM_W'(prod_b_ff);
      div_den   = DEN_W'({prod_b_ff, 1'b0});
      div_start = (state_ff == S_DIVST);
      if (zero_ff) begin
         capped = '0;
      end else if (div_quot == '0) begin
         capped = SEG_W'(1);
      end else if (div_quot > NUM_W'(n_eff)) begin
         capped = n_eff;
      end else begin
         capped = SEG_W'(div_quot);
      end
   end

   slbph_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .busy(div_busy),
      .done(div_done),
      .quot(div_quot)
   );

   // Color bands: below half, below three quarters, then the top band.
   always_comb begin
      three_q = ({2'b00, n_eff} * (SEG_W + 2)'(3)) >> 2;
      if (idx_ff < (n_eff >> 1)) begin
         bar_color = cfg.color_low;
      end else if ((SEG_W + 2)'(idx_ff) < three_q) begin
         bar_color = cfg.color_mid;
      end else begin
         bar_color = cfg.color_high;
      end
   end

   always_comb begin
      if (pm_ff && old_ff != '0) begin
         post_bar = S_UNMARK;
      end else if (pm_ff && new_ff != '0) begin
         post_bar = S_MARK;
      end else begin
         post_bar = S_IDLE;
      end
   end

   always_comb begin
      if (item_ff.sample_value > cfg.max_value) begin
         add_kind = KIND_TOO_LARGE;
      end else if (item_ff.sample_value < cfg.min_value) begin
         add_kind = KIND_TOO_SMALL;
      end else begin
         add_kind = KIND_ACCEPTED;
      end
      sum_wide = {1'b0, sum_ff} + {17'd0, item_ff.sample_value};
   end

   assign can_emit = !rsp_valid_ff || rsp_ready;

   always_comb begin
      emit               = 1'b0;
      commit             = 1'b0;
      emit_res.kind      = KIND_NO_CHANGE;
      emit_res.segment   = 5'd0;
      emit_res.color     = 16'd0;
      emit_res.lit_count = 6'(lit_ff);
      emit_res.last      = 1'b1;
      unique case (state_ff)
         S_ADD: begin
            emit               = can_emit;
            emit_res.kind      = add_kind;
            emit_res.lit_count = 6'(shown_lit_ff);
         end
         S_BAR: begin
            emit             = can_emit;
            emit_res.kind    = grow_ff ? KIND_FILL : KIND_ERASE;
            emit_res.segment = 5'(idx_ff);
            emit_res.color   = grow_ff ? bar_color : cfg.background_color;
            emit_res.last    = (idx_ff == end_ff) && (post_bar == S_IDLE);
            commit           = can_emit && emit_res.last;
         end
         S_UNMARK: begin
            emit             = can_emit;
            emit_res.kind    = KIND_UNMARK;
            emit_res.segment = 5'(old_ff - SEG_W'(1));
            emit_res.color   = cfg.background_color;
            emit_res.last    = 1'b0;
         end
         S_RESTORE: begin
            emit             = can_emit;
            emit_res.kind    = KIND_RESTORE;
            emit_res.segment = 5'(old_ff - SEG_W'(1));
            emit_res.color   = cfg.border_color;
            emit_res.last    = (new_ff == '0);
            commit           = can_emit && emit_res.last;
         end
         S_MARK: begin
            emit             = can_emit;
            emit_res.kind    = KIND_MARK;
            emit_res.segment = 5'(new_ff - SEG_W'(1));
            emit_res.color   = cfg.color_high;
            commit           = can_emit;
         end
         S_NONE: begin
            emit   = can_emit;
            commit = can_emit;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign item_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         sel_ff         <= SEL_LIT;
         rsp_valid_ff   <= 1'b0;
         sum_ff         <= '0;
         count_ff       <= '0;
         shown_lit_ff   <= '0;
         shown_peak_ff  <= '0;
         bucket_open_ff <= 1'b0;
         start_ms_ff    <= '0;
         for (int i = 0; i < PEAK_WINDOW; i++) begin
            bucket_ff[i] <= '0;
         end
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= emit_res;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit) begin
            shown_lit_ff  <= lit_ff;
            shown_peak_ff <= peak_ff;
            sum_ff        <= '0;
            count_ff      <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  item_ff <= item;
                  walk_ff <= '0;
                  peak_ff <= '0;
                  state_ff <= (item.operation == OP_ADD) ? S_ADD : S_PEAK;
               end
            end
            S_ADD: begin
               if (can_emit) begin
                  if (add_kind == KIND_ACCEPTED) begin
                     // Newest bucket sits at the bottom; a full window drops the top one.
                     if (!bucket_open_ff ||
                         (item_ff.now_ms - start_ms_ff) > BUCKET_MS) begin
                        for (int i = 1; i < PEAK_WINDOW; i++) begin
                           bucket_ff[i] <= bucket_ff[i-1];
                        end
                        bucket_ff[0]   <= item_ff.sample_value;
                        start_ms_ff    <= item_ff.now_ms;
                        bucket_open_ff <= 1'b1;
                     end else if (item_ff.sample_value > bucket_ff[0]) begin
                        bucket_ff[0] <= item_ff.sample_value;
                     end
                     sum_ff <= sum_wide[32] ? '1 : sum_wide[31:0];
                     if (count_ff != '1) begin
                        count_ff <= count_ff + COUNT_BITS'(1);
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_PEAK: begin
               if (bucket_ff[walk_ff] > peak_ff) begin
                  peak_ff <= bucket_ff[walk_ff];
               end
               if (walk_ff == WALK_W'(PEAK_WINDOW - 1)) begin
                  sel_ff   <= SEL_LIT;
                  state_ff <= S_MUL;
               end else begin
                  walk_ff <= walk_ff + WALK_W'(1);
               end
            end
            S_MUL: begin
               prod_a_ff <= PROD_A_W'(div_s) * PROD_A_W'(n_eff);
               prod_b_ff <= PROD_B_W'(div_c) * PROD_B_W'(mx_eff);
               zero_ff   <= (div_s == 32'd0) || (div_c == '0);
               state_ff  <= S_DIVST;
            end
            S_DIVST: begin
               state_ff <= S_DIVWAIT;
            end
            S_DIVWAIT: begin
               if (div_done) begin
                  case (sel_ff)
                     SEL_LIT: begin
                        lit_ff <= capped;
                        if (peak_ff != shown_peak_ff) begin
                           sel_ff   <= SEL_OLD;
                           state_ff <= S_MUL;
                        end else begin
                           pm_ff    <= 1'b0;
                           state_ff <= S_PLAN;
                        end
                     end
                     SEL_OLD: begin
                        old_ff   <= capped;
                        sel_ff   <= SEL_NEW;
                        state_ff <= S_MUL;
                     end
                     default: begin
                        new_ff   <= capped;
                        pm_ff    <= 1'b1;
                        state_ff <= S_PLAN;
                     end
                  endcase
               end
            end
            S_PLAN: begin
               if (lit_ff > shown_lit_ff) begin
                  grow_ff  <= 1'b1;
                  idx_ff   <= shown_lit_ff;
                  end_ff   <= lit_ff - SEG_W'(1);
                  state_ff <= S_BAR;
               end else if (lit_ff < shown_lit_ff) begin
                  grow_ff  <= 1'b0;
                  idx_ff   <= lit_ff;
                  end_ff   <= shown_lit_ff - SEG_W'(1);
                  state_ff <= S_BAR;
               end else begin
                  state_ff <= (post_bar == S_IDLE) ? S_NONE : post_bar;
               end
            end
            S_BAR: begin
               if (can_emit) begin
                  if (idx_ff == end_ff) begin
                     state_ff <= post_bar;
                  end else begin
                     idx_ff <= idx_ff + SEG_W'(1);
                  end
               end
            end
            S_UNMARK: begin
               if (can_emit) begin
                  state_ff <= S_RESTORE;
               end
            end
            S_RESTORE: begin
               if (can_emit) begin
                  state_ff <= (new_ff != '0) ? S_MARK : S_IDLE;
               end
            end
            S_MARK: begin
               if (can_emit) begin
                  state_ff <= S_IDLE;
               end
            end
            S_NONE: begin
               if (can_emit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_lit_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(shown_lit_ff) <= 32'(SEGMENTS_MAX))
      else $error("shown segment count beyond the bar");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_busy)
      else $error("divider running while the sequencer is idle");

   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      commit |=> (sum_ff == 32'd0) && (count_ff == '0))
      else $error("accumulator not cleared after an update");

endmodule

@@ sim/segmented_level_bar_with_peak_hold_tb.sv @@
// Self-checking testbench of the segmented level bar with peak hold.
`timescale 1ns / 100ps
module segmented_level_bar_with_peak_hold_tb;
   import slbph_pkg::*;

   localparam int SEG_MAX = 32;
   localparam int WINDOW = 8;
   localparam int CNT_LIMIT = 65535;
   localparam int LIMIT_CYCLES = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   segmented_level_bar_with_peak_hold uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   cfg_type cfg;
   logic [31:0] acc_sum;
   logic [15:0] acc_count;
   logic [5:0] lit_shown;
   logic [15:0] peak_shown;
   logic [15:0] maxima [WINDOW];
   int unsigned maxima_used;
   logic [31:0] bucket_open_ms;

   result_type pending_cmds[$];
   result_type first_pred;
   int errors = 0;
   int checked = 0;
   int updates_sent = 0;
   int adds_sent = 0;
   longint cycles = 0;

   task automatic report(input string what, input result_type got, input result_type want);
      $write("mismatch %s: got kind %0d seg %0d color %h lit %0d last %0d, ",
             what, got.kind, got.segment, got.color, got.lit_count, got.last);
      $display("want kind %0d seg %0d color %h lit %0d last %0d",
               want.kind, want.segment, want.color, want.lit_count, want.last);
      errors++;
   endtask

   function automatic int unsigned bar_segments();
      if (cfg.num_segments < 1) return 1;
      if (cfg.num_segments > SEG_MAX) return SEG_MAX;
      return cfg.num_segments;
   endfunction

   function automatic int unsigned level_to_lit(longint unsigned sum, longint unsigned cnt);
      longint unsigned n, mx, l;
      n = bar_segments();
      mx = (cfg.max_value == 0) ? 1 : cfg.max_value;
      if (cnt == 0 || sum == 0) return 0;
      l = (2 * sum * n + cnt * mx) / (2 * cnt * mx);
      if (l == 0) l = 1;
      if (l > n) l = n;
      return 32'(l);
   endfunction

   function automatic logic [15:0] third_color(int unsigned s);
      int unsigned n;
      n = bar_segments();
      if (s < n / 2) return cfg.color_low;
      if (s < n * 3 / 4) return cfg.color_mid;
      return cfg.color_high;
   endfunction

   function automatic void push_cmd(kind_type k, int unsigned seg, logic [15:0] col,
                                    int unsigned lit);
      result_type r;
      r.kind = k;
      r.segment = seg[4:0];
      r.color = col;
      r.lit_count = lit[5:0];
      r.last = 1'b0;
      pending_cmds.push_back(r);
   endfunction

   function automatic void track_peak(logic [15:0] v, logic [31:0] now);
      if (maxima_used == 0 || (now - bucket_open_ms) > BUCKET_MS) begin
         bucket_open_ms = now;
         if (maxima_used < WINDOW) begin
            maxima[maxima_used] = v;
            maxima_used++;
         end else begin
            for (int i = 1; i < WINDOW; i++) maxima[i - 1] = maxima[i];
            maxima[WINDOW - 1] = v;
         end
      end else if (v > maxima[maxima_used - 1]) begin
         maxima[maxima_used - 1] = v;
      end
   endfunction

   // Works out the commands one item causes and queues them.
   function automatic void predict_commands(item_type it);
      int unsigned lit, old_lit, new_lit, first;
      logic [15:0] peak;
      kind_type k;
      first = pending_cmds.size();
      if (it.operation == OP_ADD) begin
         if (it.sample_value > cfg.max_value) k = KIND_TOO_LARGE;
         else if (it.sample_value < cfg.min_value) k = KIND_TOO_SMALL;
         else begin
            k = KIND_ACCEPTED;
            track_peak(it.sample_value, it.now_ms);
            if (acc_sum > 32'hFFFFFFFF - it.sample_value) acc_sum = 32'hFFFFFFFF;
            else acc_sum = acc_sum + it.sample_value;
            if (acc_count < CNT_LIMIT) acc_count++;
         end
         push_cmd(k, 0, 16'h0, lit_shown);
      end else begin
         lit = level_to_lit(acc_sum, acc_count);
         peak = '0;
         for (int i = 0; i < WINDOW; i++) if (maxima[i] > peak) peak = maxima[i];
         if (lit > lit_shown)
            for (int unsigned i = lit_shown; i < lit; i++)
               push_cmd(KIND_FILL, i, third_color(i), lit);
         else if (lit < lit_shown)
            for (int unsigned i = lit; i < lit_shown; i++)
               push_cmd(KIND_ERASE, i, cfg.background_color, lit);
         if (peak != peak_shown) begin
            old_lit = level_to_lit(peak_shown, 1);
            new_lit = level_to_lit(peak, 1);
            if (old_lit > 0) begin
               push_cmd(KIND_UNMARK, old_lit - 1, cfg.background_color, lit);
               push_cmd(KIND_RESTORE, old_lit - 1, cfg.border_color, lit);
            end
            if (new_lit > 0) push_cmd(KIND_MARK, new_lit - 1, cfg.color_high, lit);
         end
         if (pending_cmds.size() == first) push_cmd(KIND_NO_CHANGE, 0, 16'h0, lit);
         lit_shown = lit[5:0];
         peak_shown = peak;
         acc_sum = '0;
         acc_count = '0;
      end
      pending_cmds[pending_cmds.size() - 1].last = 1'b1;
      first_pred = pending_cmds[first];
   endfunction

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // Result checker and random receiver stalls.
   int stall_left = 0;
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = kind_type'(rsp_tuser);
         got.segment = rsp_tdata[4:0];
         got.color = rsp_tdata[20:5];
         got.lit_count = rsp_tdata[26:21];
         got.last = rsp_tlast;
         if (pending_cmds.size() == 0) begin
            want = '0;
            report("unexpected result", got, want);
         end else begin
            want = pending_cmds.pop_front();
            checked++;
            if (got.kind != want.kind) report("kind", got, want);
            else if (got.segment != want.segment) report("segment", got, want);
            else if (got.color != want.color) report("color", got, want);
            else if (got.lit_count != want.lit_count) report("lit_count", got, want);
            else if (got.last != want.last) report("last", got, want);
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 5) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         REG_MIN_VALUE:    cfg.min_value = val;
         REG_MAX_VALUE:    cfg.max_value = val;
         REG_NUM_SEGMENTS: cfg.num_segments = val[5:0];
         REG_BACKGROUND:   cfg.background_color = val;
         REG_BORDER:       cfg.border_color = val;
         REG_COLOR_LOW:    cfg.color_low = val;
         REG_COLOR_MID:    cfg.color_mid = val;
         default:          cfg.color_high = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // Drives one item, sometimes after a random gap unless gap_free is set; called at a falling edge.
   logic gap_free = 1'b0;
   task automatic send_item(item_type it);
      int gap;
      gap = 0;
      if (!gap_free && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.operation;
      req_tdata <= {it.now_ms, it.sample_value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_commands(it);
      if (it.operation == OP_UPDATE) updates_sent++;
      else adds_sent++;
      @(negedge clock);
   endtask

   function automatic item_type mk(op_type op, logic [15:0] v, logic [31:0] t);
      item_type it;
      it.operation = op;
      it.sample_value = v;
      it.now_ms = t;
      return it;
   endfunction

   task automatic idle_line();
      req_tvalid <= 1'b0;
   endtask

   // Directed table: extremes, saturation, timestamp wrap.
   item_type directed [] = '{
      '{OP_UPDATE, 16'h0000, 32'h0},          // nothing at all: no change
      '{OP_ADD,    16'h0000, 32'h0},          // zero sample opens first bucket
      '{OP_UPDATE, 16'h0000, 32'h0},
      '{OP_ADD,    16'hFFFF, 32'hFFFFFFFF},
      '{OP_ADD,    16'hFFFF, 32'h000003E7},   // wraps: exactly 1000 later, same bucket
      '{OP_ADD,    16'h8000, 32'h000003E8},   // 1001 later: new bucket
      '{OP_UPDATE, 16'hFFFF, 32'hFFFFFFFF},
      '{OP_ADD,    16'h0001, 32'h00010000},
      '{OP_UPDATE, 16'h0000, 32'h0},
      '{OP_UPDATE, 16'h0000, 32'h0},
      '{OP_ADD,    16'h1234, 32'h00100000},
      '{OP_ADD,    16'h4321, 32'h00200000},
      '{OP_UPDATE, 16'h0000, 32'h0}
   };

   // Rows whose first result is obvious; kind checked directly, rest by predictor.
   kind_type directed_kind [] = '{
      KIND_NO_CHANGE, KIND_ACCEPTED, KIND_NO_CHANGE, KIND_ACCEPTED, KIND_ACCEPTED,
      KIND_ACCEPTED, KIND_FILL, KIND_ACCEPTED, KIND_ERASE, KIND_ERASE,
      KIND_ACCEPTED, KIND_ACCEPTED, KIND_FILL
   };

   task automatic random_phase(int count, logic [31:0] base_ms);
      item_type it;
      logic [31:0] t;
      t = base_ms;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            it = mk(OP_UPDATE, 16'($urandom), $urandom);
         end else begin
            t = t + (($urandom_range(0, 3) == 0) ? $urandom_range(900, 3000)
                                                : $urandom_range(0, 400));
            if ($urandom_range(0, 9) == 0) t = $urandom;
            it = mk(OP_ADD, ($urandom_range(0, 2) == 0) ? 16'($urandom)
                            : 16'($urandom_range(cfg.min_value, cfg.max_value)), t);
         end
         send_item(it);
      end
   endtask

   initial begin
      result_type r, want;
      cfg = '{min_value: 16'd0, max_value: 16'hFFFF, num_segments: 6'd8,
              background_color: 16'h0, border_color: 16'hFFFF, color_low: 16'h0,
              color_mid: 16'h0, color_high: 16'h0};
      acc_sum = '0;
      acc_count = '0;
      lit_shown = '0;
      peak_shown = '0;
      for (int i = 0; i < WINDOW; i++) maxima[i] = '0;
      maxima_used = 0;
      bucket_open_ms = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(REG_BORDER, 16'hF800);
      write_reg(REG_COLOR_LOW, 16'h07E0);
      write_reg(REG_COLOR_MID, 16'hFFE0);
      write_reg(REG_COLOR_HIGH, 16'hF800);
      write_reg(REG_BACKGROUND, 16'h0841);
      write_reg(REG_NUM_SEGMENTS, 6'd32);
      for (int i = 0; i < directed.size(); i++) begin
         send_item(directed[i]);
         if (first_pred.kind != directed_kind[i]) begin
            r = first_pred;
            want = r;
            want.kind = directed_kind[i];
            report("directed row", r, want);
         end
      end
      idle_line();
      // Rejections: too large wins over too small.
      drain();
      write_reg(REG_MIN_VALUE, 16'd2000);
      write_reg(REG_MAX_VALUE, 16'd1000);
      send_item(mk(OP_ADD, 16'd1500, 32'd5));
      send_item(mk(OP_ADD, 16'd500, 32'd6));
      send_item(mk(OP_UPDATE, 16'd0, 32'd0));
      idle_line();

      // The sender holds off until every expected result has come.
      drain();
      write_reg(REG_MIN_VALUE, 16'd100);
      write_reg(REG_MAX_VALUE, 16'd40000);
      write_reg(REG_NUM_SEGMENTS, 6'd13);
      random_phase(45, 32'hFFFFF000);
      idle_line();
      drain();
      write_reg(REG_MIN_VALUE, 16'd0);
      write_reg(REG_MAX_VALUE, 16'd0);
      write_reg(REG_NUM_SEGMENTS, 6'd0);
      random_phase(20, 32'd0);
      idle_line();
      drain();
      write_reg(REG_MAX_VALUE, 16'hFFFF);
      write_reg(REG_NUM_SEGMENTS, 6'd63);
      write_reg(REG_BACKGROUND, 16'($urandom));
      write_reg(REG_COLOR_LOW, 16'($urandom));
      write_reg(REG_COLOR_HIGH, 16'($urandom));
      gap_free = 1'b1;
      random_phase(25, 32'd77);
      gap_free = 1'b0;
      random_phase(25, 32'h80000000);
      idle_line();
      drain();

      $display("covered %0d adds and %0d updates, %0d results checked",
               adds_sent, updates_sent, checked);
      if (errors == 0 && pending_cmds.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
